// File: rtl/core/dtrs_pkg.sv
// Shared constants and request record for the disk request track sorter.
package dtrs_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  localparam int unsigned TrackW  = 10;
  localparam int unsigned SurfW   = 3;
  localparam int unsigned RunW    = 5;
  localparam int unsigned SectW   = 6;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned EntryW  = TrackW + SurfW + 1 + RunW + SectW + TimeW;
  localparam int unsigned TdataW  = ((EntryW + 7) / 8) * 8;
  localparam int unsigned RankW   = TrackW + AddrW;

  // Stored request, first field in the highest bits (track in the lowest bits)
  typedef struct packed {
    logic [TimeW-1:0]  created_at;
    logic [SectW-1:0]  start_sector;
    logic [RunW-1:0]   sector_run;
    logic              write_access;
    logic [SurfW-1:0]  surface;
    logic [TrackW-1:0] track;
  } req_t;

endpackage

// File: rtl/core/dtrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dtrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/disk_request_track_sorter.sv
// Top level: batch loader and elevator-order emitter for disk requests.
//
// Requests enter on the s_axis channel, one transfer per cycle while loading.
// The transfer with tlast set closes the batch. Up to 64 requests are kept in
// a request RAM; later ones of the same batch are dropped and the batch's
// results then carry tuser = 1 (overflow).
// After the closing transfer the block emits the batch on m_axis sorted by
// track: descending when direction is 0, ascending when 1; equal tracks keep
// arrival order. m_axis tlast marks the final result.
// Each result is found by one full pass over the stored requests (one read per
// cycle, read data registered in the RAM); the single RAM read port limits how
// fast a batch drains. s_axis is not ready while a batch drains.
// A stalled receiver holds the output register and pauses the next emit.
// Reset empties the batch, clears the overflow mark, sets direction to 0 and
// drops any pending result; RAM contents are left as they are.
// The user writes direction through cfg_we_i / cfg_wdata_i only while the block idles (not enforced).
module disk_request_track_sorter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,    // direction
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // track, surface, write_access, sector_run, start_sector, created_at
  input  logic [dtrs_pkg::TdataW-1:0] s_axis_tdata,
  input  logic                        s_axis_tlast,   // batch_end
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_track, out_surface, out_write_access, out_sector_run,
  // out_start_sector, out_created_at
  output logic [dtrs_pkg::TdataW-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,   // out_last
  output logic                        m_axis_tuser    // batch_overflow
);

  typedef enum logic [1:0] {
    StLoad,
    StScan,
    StEmit
  } state_e;

  state_e                        state_q, state_d;
  logic                          dir_q;
  logic [dtrs_pkg::CntW-1:0]     count_q, count_d;
  logic                          drop_q, drop_d;
  logic [dtrs_pkg::CntW-1:0]     scan_q, scan_d;
  logic [dtrs_pkg::CntW-1:0]     emit_cnt_q, emit_cnt_d;
  logic                          pv_q, pv_d;
  logic [dtrs_pkg::AddrW-1:0]    pidx_q, pidx_d;
  logic                          best_v_q, best_v_d;
  logic [dtrs_pkg::RankW-1:0]    best_rank_q, best_rank_d;
  dtrs_pkg::req_t                best_q, best_d;
  logic                          have_last_q, have_last_d;
  logic [dtrs_pkg::RankW-1:0]    last_rank_q, last_rank_d;
  logic                          ov_q, ov_d;
  dtrs_pkg::req_t                out_q, out_d;
  logic                          olast_q, olast_d;
  logic                          oflow_q, oflow_d;

  logic                          in_xfer;
  logic                          out_xfer;
  logic                          ram_we;
  logic [dtrs_pkg::AddrW-1:0]    ram_raddr;
  logic [dtrs_pkg::EntryW-1:0]   ram_rdata;
  dtrs_pkg::req_t                rd_req;
  logic [dtrs_pkg::TrackW-1:0]   rd_key;
  logic [dtrs_pkg::RankW-1:0]    cand_rank;
  logic                          room;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = ov_q && m_axis_tready;
  assign s_axis_tready = (state_q == StLoad);
  assign room          = (count_q < dtrs_pkg::CntW'(dtrs_pkg::QueueDepth));
  assign ram_we        = in_xfer && room;
  assign ram_raddr     = scan_q[dtrs_pkg::AddrW-1:0];
  assign rd_req        = dtrs_pkg::req_t'(ram_rdata);
  assign rd_key        = dir_q ? rd_req.track : ~rd_req.track;
  assign cand_rank     = {rd_key, pidx_q};

  dtrs_ram #(
    .Width (dtrs_pkg::EntryW),
    .Depth (dtrs_pkg::QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[dtrs_pkg::AddrW-1:0]),
    .wdata_i (s_axis_tdata[dtrs_pkg::EntryW-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequence load, scan and emit
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    scan_d      = scan_q;
    emit_cnt_d  = emit_cnt_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    best_v_d    = best_v_q;
    best_rank_d = best_rank_q;
    best_d      = best_q;
    have_last_d = have_last_q;
    last_rank_d = last_rank_q;
    ov_d        = ov_q && !out_xfer;
    out_d       = out_q;
    olast_d     = olast_q;
    oflow_d     = oflow_q;
    unique case (state_q)
      StLoad: begin
        if (in_xfer) begin
          if (room) begin
            count_d = count_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d     = StScan;
            scan_d      = '0;
            emit_cnt_d  = '0;
            have_last_d = 1'b0;
            best_v_d    = 1'b0;
          end
        end
      end
      StScan: begin
        // Issue one read per cycle, compare the data in the following cycle
        if (scan_q < count_q) begin
          pv_d   = 1'b1;
          pidx_d = scan_q[dtrs_pkg::AddrW-1:0];
          scan_d = scan_q + 1'b1;
        end else if (!pv_q) begin
          state_d = StEmit;
        end
        if (pv_q && (!have_last_q || cand_rank > last_rank_q) &&
            (!best_v_q || cand_rank < best_rank_q)) begin
          best_v_d    = 1'b1;
          best_rank_d = cand_rank;
          best_d      = rd_req;
        end
      end
      StEmit: begin
        if (!ov_q || out_xfer) begin
          ov_d        = 1'b1;
          out_d       = best_q;
          olast_d     = (emit_cnt_q + 1'b1 == count_q);
          oflow_d     = drop_q;
          emit_cnt_d  = emit_cnt_q + 1'b1;
          have_last_d = 1'b1;
          last_rank_d = best_rank_q;
          best_v_d    = 1'b0;
          scan_d      = '0;
          if (emit_cnt_q + 1'b1 == count_q) begin
            state_d = StLoad;
            count_d = '0;
            drop_d  = 1'b0;
          end else begin
            state_d = StScan;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      dir_q       <= 1'b0;
      count_q     <= '0;
      drop_q      <= 1'b0;
      scan_q      <= '0;
      emit_cnt_q  <= '0;
      pv_q        <= 1'b0;
      best_v_q    <= 1'b0;
      have_last_q <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      drop_q      <= drop_d;
      scan_q      <= scan_d;
      emit_cnt_q  <= emit_cnt_d;
      pv_q        <= pv_d;
      best_v_q    <= best_v_d;
      have_last_q <= have_last_d;
      ov_q        <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pidx_q      <= pidx_d;
    best_rank_q <= best_rank_d;
    best_q      <= best_d;
    last_rank_q <= last_rank_d;
    out_q       <= out_d;
    olast_q     <= olast_d;
    oflow_q     <= oflow_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = dtrs_pkg::TdataW'(out_q);
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = oflow_q;

  // Fill never passes the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dtrs_pkg::CntW'(dtrs_pkg::QueueDepth))
    else $error("entry count above queue depth");

  // A draining batch is never empty
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> (count_q != '0))
    else $error("draining an empty batch");

  // Emitted count stays within the batch
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> (emit_cnt_q < count_q))
    else $error("emitted more results than stored");

  // An emit always finds a candidate
  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> best_v_q)
    else $error("emit without a selected entry");

endmodule
